[rtl/core/oid_pkg.sv]
package oid_pkg;

   localparam logic [7:0] SplitBase  = 8'd40;
   localparam logic [7:0] MoreFlag   = 8'h80;
   localparam logic [6:0] SeptetMask = 7'h7F;

   // byte / 40 as (byte * 205) >> 13, exact for every 8-bit byte
   localparam logic [15:0] SplitRecip = 16'd205;
   localparam int          RecipShift = 13;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       first_byte;
      logic       final_byte;
      logic       relative_id;
   } req_type;

   typedef struct packed {
      logic [31:0] arc_value;
      logic        from_first_pair;
      logic        identifier_done;
      logic        last_of_run;
   } rsp_type;

   typedef struct packed {
      logic has_result;
      logic last_beat;
   } oid_ctrl_type;

endpackage

[rtl/core/oid_arc_unit.sv]
module oid_arc_unit
   import oid_pkg::*;
(
   input  req_type      item,
   input  logic [31:0]  acc_value,
   input  logic         phase,
   output rsp_type      result,
   output oid_ctrl_type ctrl,
   output logic [31:0]  acc_next
);

   logic        split;
   logic [31:0] base;
   logic [31:0] shifted;
   logic [15:0] prod;
   logic [2:0]  quot;
   logic [7:0]  quot_x40;
   logic [7:0]  rem;

   assign split    = item.first_byte && !item.relative_id;
   assign base     = item.first_byte ? 32'd0 : acc_value;
   assign shifted  = {base[24:0], 7'd0};
   assign prod     = {8'd0, item.data_byte} * SplitRecip;
   assign quot     = prod[RecipShift+2:RecipShift];
   assign quot_x40 = 8'({5'd0, quot} * SplitBase);
   assign rem      = item.data_byte - quot_x40;

   always_comb begin
      result.from_first_pair = split;
      result.identifier_done = item.final_byte;
      result.last_of_run     = 1'b1;
      result.arc_value       = shifted + {24'd0, item.data_byte};
      ctrl.has_result        = 1'b1;
      ctrl.last_beat         = 1'b1;
      acc_next               = 32'd0;
      if (split) begin
         result.last_of_run = phase;
         ctrl.last_beat     = phase;
         result.arc_value   = phase ? {24'd0, rem} : {29'd0, quot};
      end else if ((item.data_byte & MoreFlag) != 8'd0) begin
         ctrl.has_result = 1'b0;
         acc_next        = shifted + {25'd0, item.data_byte[6:0] & SeptetMask};
      end
      if (item.final_byte) begin
         acc_next = 32'd0;
      end
   end

endmodule

[rtl/core/object_identifier_decoder_top.sv]
// channel   direction  payload   handshake
// req       in         req_type  req_valid / req_stall
// rsp       out        rsp_type  rsp_valid / rsp_stall
//
// one byte per cycle through the input register while req_stall is low; a split first byte of an
// absolute identifier holds that register until both of its result beats are loaded
// a req beat is registered in the input register, then its first rsp beat in the rsp register
// continuation bytes produce no rsp beat and leave without waiting on rsp_stall
// reset is synchronous and clears both valid registers, phase and accumulator
// req_stall rises only while the input register cannot hand off its item
module object_identifier_decoder_top
   import oid_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   logic         a_valid_ff, a_valid_in;
   req_type      a_item_ff, a_item_in;
   logic         phase_ff, phase_in;
   logic [31:0]  acc_ff, acc_in;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_type      rsp_data_ff, rsp_data_in;

   rsp_type      result;
   oid_ctrl_type ctrl;
   logic [31:0]  acc_next;
   logic         out_free;
   logic         load;
   logic         advance;
   logic         req_take;

   oid_arc_unit u_arc (
      .item      (a_item_ff),
      .acc_value (acc_ff),
      .phase     (phase_ff),
      .result    (result),
      .ctrl      (ctrl),
      .acc_next  (acc_next)
   );

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign load      = a_valid_ff && ctrl.has_result && out_free;
   assign advance   = a_valid_ff && (!ctrl.has_result || (out_free && ctrl.last_beat));
   assign req_stall = a_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      a_valid_in   = req_take || (a_valid_ff && !advance);
      a_item_in    = req_take ? req_data : a_item_ff;
      phase_in     = advance ? 1'b0 : (load ? 1'b1 : phase_ff);
      acc_in       = advance ? acc_next : acc_ff;
      rsp_valid_in = load || (rsp_valid_ff && rsp_stall);
      rsp_data_in  = load ? result : rsp_data_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff   <= 1'b0;
         phase_ff     <= 1'b0;
         acc_ff       <= 32'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         a_valid_ff   <= a_valid_in;
         phase_ff     <= phase_in;
         acc_ff       <= acc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      a_item_ff   <= a_item_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_quot_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.from_first_pair && !rsp_data_ff.last_of_run
      |-> rsp_data_ff.arc_value <= 32'd6)
      else $error("quotient beat out of range");

   a_rem_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.from_first_pair && rsp_data_ff.last_of_run
      |-> rsp_data_ff.arc_value < 32'd40)
      else $error("remainder beat out of range");

   a_single_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_data_ff.from_first_pair |-> rsp_data_ff.last_of_run)
      else $error("ordinary arc beat without last_of_run");

   a_phase_held: assert property (@(posedge clock) disable iff (reset)
      phase_ff |-> a_valid_ff && a_item_ff.first_byte && !a_item_ff.relative_id)
      else $error("second split beat pending without a split item");

   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid_ff && !a_valid_ff && acc_ff == 32'd0)
      else $error("state not cleared by reset");

endmodule
